/* rtl/core/idle_sleep_window_backoff_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the idle sleep window block
// Concurrent checks clocked on clk and masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IDLE_SLEEP_WINDOW_BACKOFF_ASSERT_SVH
`define IDLE_SLEEP_WINDOW_BACKOFF_ASSERT_SVH

// Same-cycle implication
`define ISW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ISW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/isw_pkg.sv */
// ----------------------------------------------------------------------------
// isw_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package isw_pkg;

    localparam int TIME_W    = 32;
    localparam int WIN_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = TIME_W;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int STEP_W    = 6;
    localparam int STEP_CAP  = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd4;

    typedef struct packed {
        logic load;       // capture the input transaction
        logic check_res;  // result from the threshold/ramp check
        logic div_init;   // start the divider
        logic div_step;   // one quotient bit
        logic dbl_init;   // seed window and doubling count
        logic dbl_step;   // one doubling
        logic fin;        // clamp window into the result
        logic store;      // move result into the output register
    } isw_cmd_t;

    typedef struct packed {
        logic skip_zero;
        logic ramp_zero;
        logic steps_zero;
        logic out_free;
    } isw_status_t;

endpackage

/* rtl/core/isw_ctrl.sv */
// ----------------------------------------------------------------------------
// isw_ctrl
// Sequencer: check, iterative divide, doubling loop, hand-off to output.
// ----------------------------------------------------------------------------
module isw_ctrl
    import isw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  isw_status_t status,
    output isw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        DIV,
        SETUP,
        DBL,
        DONE
    } state_t;

    localparam logic [CNT_W-1:0] DivLast = CNT_W'(DIV_W - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                if (status.skip_zero || status.ramp_zero)
                begin
                    cmd.check_res = 1'b1;
                    state_next    = DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = DIV;
                end
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DivLast)
                    state_next = SETUP;
            end
            SETUP:
            begin
                cmd.dbl_init = 1'b1;
                state_next   = DBL;
            end
            DBL:
            begin
                if (status.steps_zero)
                begin
                    cmd.fin    = 1'b1;
                    state_next = DONE;
                end
                else
                    cmd.dbl_step = 1'b1;
            end
            DONE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
                state_next = IDLE;
        endcase
    end

endmodule

/* rtl/core/isw_dp.sv */
// ----------------------------------------------------------------------------
// isw_dp
// Configuration registers, idle-time subtract, restoring divider,
// doubling unit, clamp and output register.
// ----------------------------------------------------------------------------
module isw_dp
    import isw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data,
    input  logic [TIME_W-1:0]    now_time,
    input  logic [TIME_W-1:0]    last_active_time,
    input  isw_cmd_t             cmd,
    output isw_status_t          status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WIN_W-1:0]     sleep_window
);

    logic              enable_reg;
    logic [WIN_W-1:0]  thr_reg, min_reg, max_reg, ramp_reg;

    logic [TIME_W-1:0] idle_reg;
    logic [DIV_W-1:0]  quo_reg, rem_reg;
    logic [WIN_W-1:0]  win_reg, res_reg, out_data_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              out_valid_reg;

    logic [WIN_W-1:0]  ceil_w;
    logic [TIME_W:0]   over_thr;
    logic [DIV_W:0]    trial;
    logic              trial_ge;
    logic [STEP_W-1:0] steps_sat;
    logic [WIN_W-1:0]  win_clamp;

    assign ceil_w   = (max_reg < min_reg) ? min_reg : max_reg;
    assign over_thr = {1'b0, idle_reg} - {1'b0, thr_reg};
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, ramp_reg});

    assign steps_sat = (quo_reg > DIV_W'(STEP_CAP)) ? STEP_W'(STEP_CAP)
                                                     : quo_reg[STEP_W-1:0];

    always_comb
    begin
        win_clamp = (win_reg > ceil_w) ? ceil_w : win_reg;
        if (win_clamp < min_reg)
            win_clamp = min_reg;
    end

    assign status.skip_zero  = !enable_reg || over_thr[TIME_W];
    assign status.ramp_zero  = (ramp_reg == '0);
    assign status.steps_zero = (steps_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            thr_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            ramp_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:    enable_reg <= cfg_data[0];
                REG_THRESHOLD: thr_reg    <= cfg_data;
                REG_MIN_WIN:   min_reg    <= cfg_data;
                REG_MAX_WIN:   max_reg    <= cfg_data;
                REG_RAMP_STEP: ramp_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            idle_reg <= now_time - last_active_time;

        if (cmd.check_res)
            res_reg <= status.skip_zero ? '0 : ceil_w;
        else if (cmd.fin)
            res_reg <= win_clamp;

        if (cmd.div_init)
        begin
            quo_reg <= over_thr[TIME_W-1:0];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], trial_ge};
            rem_reg <= trial_ge ? DIV_W'(trial - {1'b0, ramp_reg}) : trial[DIV_W-1:0];
        end

        if (cmd.dbl_init)
        begin
            win_reg   <= (min_reg == '0) ? WIN_W'(1) : min_reg;
            steps_reg <= steps_sat;
        end
        else if (cmd.dbl_step)
        begin
            // saturate at the ceiling and stop doubling
            if (win_reg >= ceil_w || win_reg > (ceil_w >> 1))
            begin
                win_reg   <= ceil_w;
                steps_reg <= '0;
            end
            else
            begin
                win_reg   <= {win_reg[WIN_W-2:0], 1'b0};
                steps_reg <= steps_reg - 1'b1;
            end
        end

        if (cmd.store)
            out_data_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.store)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign sleep_window = out_data_reg;

endmodule

/* rtl/core/idle_sleep_window_backoff.sv */
// ----------------------------------------------------------------------------
// idle_sleep_window_backoff
// Sleep window with exponential backoff from idle time and configuration.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid, in_ready, now_time, last_active_time | sink
//  out     | out_valid, out_ready, sleep_window          | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | sink
//
//  Disabled, below threshold or zero ramp step: CHECK sets the result and DONE
//  stores it. Otherwise the restoring divider and the one-doubling-per-cycle
//  loop run first; DONE then waits until the output register is free.
//  One transaction is worked at a time; the output register holds a result
//  while the next transaction is accepted. Reset clears the configuration
//  registers to 0 and empties the output register. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "idle_sleep_window_backoff_assert.svh"

module idle_sleep_window_backoff
    import isw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_W-1:0]    now_time,
    input  logic [TIME_W-1:0]    last_active_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WIN_W-1:0]     sleep_window,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);

    isw_cmd_t    cmd;
    isw_status_t status;

    assign cfg_ready = 1'b1;

    isw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    isw_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .now_time         (now_time),
        .last_active_time (last_active_time),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sleep_window     (sleep_window)
    );

    `ISW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "controller took a second transaction while busy")
    `ISW_ASSERT_NOW(a_store_when_free, cmd.store, status.out_free,
        "result stored over an untaken output")
    `ISW_ASSERT_NEXT(a_store_shows, cmd.store, out_valid,
        "stored result not presented")

endmodule
